// ===== design/rgb9e5_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb9e5 package
// constants and helpers shared by the shared-exponent encoder
// ----------------------------------------------------------------------------
`default_nettype none
package rgb9e5_pkg;
  localparam logic [31:0] MaxBits = 32'h477F8000;
  localparam logic [31:0] MinBits = 32'h37800000;
  localparam logic [31:0] RoundAdd = 32'h00004000;
  localparam logic [7:0] ExpBias = 8'd111;

  function automatic logic [31:0] clamp_chan(input logic [31:0] b);
    logic [31:0] c;
    c = b;
    if (b[31]) c = '0;
    else if (b[30:23] == 8'hFF && b[22:0] != '0) c = '0;
    else if (b > MaxBits) c = MaxBits;
    return c;
  endfunction
endpackage
`default_nettype wire

// ===== design/rgb9e5_mant.sv =====
// ----------------------------------------------------------------------------
// rgb9e5 mantissa
// scales one clamped channel to the shared exponent, round half up
// ----------------------------------------------------------------------------
`default_nettype none
module rgb9e5_mant (
  input  wire logic [31:0] chan,
  input  wire logic [7:0]  e,
  output logic [8:0]       mant
);
  import rgb9e5_pkg::*;
  logic [7:0]  be;
  logic [23:0] sig;
  logic [9:0]  s;
  logic [4:0]  r;
  logic [24:0] sum;
  logic [23:0] shl;
  always_comb begin
    be = (chan[30:23] == 8'd0) ? 8'd1 : chan[30:23];
    sig = (chan[30:23] == 8'd0) ? {1'b0, chan[22:0]} : {1'b1, chan[22:0]};
    s = {2'b00, be} - 10'd15 - {2'b00, e};
    r = 5'd0;
    sum = '0;
    shl = '0;
    mant = '0;
    if (!s[9]) begin
      if (s > 10'd10) mant = 9'h1FF;
      else begin
        shl = sig << s[3:0];
        mant = shl[8:0];
      end
    end else if ((10'd0 - s) > 10'd30) begin
      mant = '0;
    end else begin
      r = 5'(10'd0 - s);
      sum = {1'b0, sig} + (25'd1 << (r - 5'd1));
      mant = 9'(sum >> r);
    end
  end
endmodule
`default_nettype wire

// ===== design/float3_to_shared_exponent_rgb9e5_top.sv =====
// ----------------------------------------------------------------------------
// float3 to rgb9e5 encoder
// Packs three float channels into one shared-exponent word. One item per clock,
// four register stages (clamp, max, exponent, then mantissas into the output
// register). A stall freezes all stages together.
// ----------------------------------------------------------------------------
`default_nettype none
module float3_to_shared_exponent_rgb9e5_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // red_bits, green_bits, blue_bits
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // packed_word
);
  import rgb9e5_pkg::*;
  logic        adv;
  logic [3:0]  v_r;
  logic [31:0] c1r_r, c1g_r, c1b_r;
  logic [31:0] c2r_r, c2g_r, c2b_r, m2_r;
  logic [31:0] c3r_r, c3g_r, c3b_r;
  logic [7:0]  e3_r;
  logic [31:0] word_r;
  logic [31:0] mx, mf, mr;
  logic [8:0]  mant_r, mant_g, mant_b;

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign out_tvalid = v_r[3];
  assign out_tdata = word_r;

  always_comb begin
    mx = c1r_r;
    if (c1g_r > mx) mx = c1g_r;
    if (c1b_r > mx) mx = c1b_r;
    mf = (m2_r < MinBits) ? MinBits : m2_r;
    mr = mf + RoundAdd;
  end

  rgb9e5_mant u_r (.chan(c3r_r), .e(e3_r), .mant(mant_r));
  rgb9e5_mant u_g (.chan(c3g_r), .e(e3_r), .mant(mant_g));
  rgb9e5_mant u_b (.chan(c3b_r), .e(e3_r), .mant(mant_b));

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1r_r <= clamp_chan(in_tdata[31:0]);
      c1g_r <= clamp_chan(in_tdata[63:32]);
      c1b_r <= clamp_chan(in_tdata[95:64]);
      c2r_r <= c1r_r; c2g_r <= c1g_r; c2b_r <= c1b_r; m2_r <= mx;
      c3r_r <= c2r_r; c3g_r <= c2g_r; c3b_r <= c2b_r; e3_r <= mr[30:23];
      word_r <= {5'(e3_r - ExpBias), mant_b, mant_g, mant_r};
    end
  end
endmodule
`default_nettype wire

// ===== design/rgb9e5_checker.sv =====
// ----------------------------------------------------------------------------
// rgb9e5 checker
// port-level properties of the encoder
// ----------------------------------------------------------------------------
`default_nettype none
module rgb9e5_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("input blocked with empty output");
  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready) else $error("input blocked with ready sink");
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown(out_tdata)) else $error("unknown output item");
endmodule
bind float3_to_shared_exponent_rgb9e5_top rgb9e5_checker u_chk (.*);
`default_nettype wire
